// ===== rtl/i2c_mbe_pkg.sv =====
`default_nettype none

package i2c_mbe_pkg;

    // Sequencer step value while no command is running
    localparam logic [4:0] STEP_IDLE = 5'd31;

    // Command modes
    localparam logic [2:0] MODE_START     = 3'd0;
    localparam logic [2:0] MODE_ALT_START = 3'd1;
    localparam logic [2:0] MODE_STOP      = 3'd2;
    localparam logic [2:0] MODE_WRITE     = 3'd3;
    localparam logic [2:0] MODE_READ      = 3'd4;
    localparam logic [2:0] MODE_ACK       = 3'd5;
    localparam logic [2:0] MODE_NACK      = 3'd6;
    localparam logic [2:0] MODE_RECOVER   = 3'd7;

    // Status codes
    localparam logic [2:0] ST_READY = 3'd0;
    localparam logic [2:0] ST_BUSY  = 3'd1;
    localparam logic [2:0] ST_ERROR = 3'd2;
    localparam logic [2:0] ST_ACK   = 3'd3;
    localparam logic [2:0] ST_NACK  = 3'd4;

    // Bits in a byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       sda_in;
    } i2c_mbe_item_t;

    typedef struct packed {
        logic [4:0]  seq_step;
        logic [2:0]  active_mode;
        logic [7:0]  shift_reg;
        logic [3:0]  bit_count;
        logic [15:0] slot_count;
        logic        scl_level;
        logic        sda_level;
        logic [2:0]  last_status;
        logic [7:0]  rx_hold;
    } i2c_mbe_state_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_mbe_step.sv =====
`default_nettype none

// One tick of the bus sequencer: current state and one item in, next state out.
module i2c_mbe_step
    import i2c_mbe_pkg::*;
(
    input  i2c_mbe_state_t cur,
    input  i2c_mbe_item_t  item,
    input  logic [15:0]    slot_ticks,
    output i2c_mbe_state_t nxt,
    output logic           done
);

    logic [15:0] slot_load;
    logic        run;
    logic        wait_en;
    logic [4:0]  wait_step;
    logic        fin_en;
    logic [2:0]  fin_status;
    logic [3:0]  bc_inc;

    // zero slot length behaves as one tick
    assign slot_load = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
    assign bc_inc    = cur.bit_count + 4'd1;

    always_comb
    begin
        nxt        = cur;
        run        = 1'b0;
        wait_en    = 1'b0;
        wait_step  = '0;
        fin_en     = 1'b0;
        fin_status = ST_READY;

        if (cur.seq_step == STEP_IDLE)
        begin
            if (item.cmd_valid)
            begin
                nxt.active_mode = item.mode;
                nxt.shift_reg   = (item.mode == MODE_WRITE) ? item.tx_byte : 8'd0;
                nxt.bit_count   = '0;
                nxt.seq_step    = '0;
                run             = 1'b1;
            end
        end
        else if (cur.slot_count > 16'd1)
        begin
            nxt.slot_count = cur.slot_count - 16'd1;
        end
        else
        begin
            run = 1'b1;
        end

        if (run)
        begin
            case (nxt.active_mode)
                MODE_START:
                begin
                    if (nxt.seq_step == 5'd0)
                    begin
                        nxt.sda_level = 1'b1; wait_en = 1'b1; wait_step = 5'd1;
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd2;
                    end
                    else if (nxt.seq_step == 5'd2)
                    begin
                        if (!item.sda_in)
                        begin
                            fin_en = 1'b1; fin_status = ST_BUSY;
                        end
                        else
                        begin
                            nxt.sda_level = 1'b0; wait_en = 1'b1; wait_step = 5'd3;
                        end
                    end
                    else if (nxt.seq_step == 5'd3)
                    begin
                        nxt.scl_level = 1'b0; wait_en = 1'b1; wait_step = 5'd4;
                    end
                    else
                    begin
                        fin_en = 1'b1; fin_status = item.sda_in ? ST_ERROR : ST_READY;
                    end
                end
                MODE_ALT_START:
                begin
                    if (nxt.seq_step == 5'd0)
                    begin
                        nxt.sda_level = 1'b1; nxt.scl_level = 1'b0;
                        wait_en = 1'b1; wait_step = 5'd1;
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd2;
                    end
                    else if (nxt.seq_step == 5'd2)
                    begin
                        if (!item.sda_in)
                        begin
                            fin_en = 1'b1; fin_status = ST_BUSY;
                        end
                        else
                        begin
                            nxt.sda_level = 1'b0; wait_en = 1'b1; wait_step = 5'd3;
                        end
                    end
                    else if (nxt.seq_step == 5'd3)
                    begin
                        nxt.scl_level = 1'b0; wait_en = 1'b1; wait_step = 5'd4;
                    end
                    else if (nxt.seq_step == 5'd4)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd5;
                    end
                    else if (nxt.seq_step == 5'd5)
                    begin
                        nxt.sda_level = 1'b1; wait_en = 1'b1; wait_step = 5'd6;
                    end
                    else if (nxt.seq_step == 5'd6)
                    begin
                        nxt.scl_level = 1'b0; wait_en = 1'b1; wait_step = 5'd7;
                    end
                    else
                    begin
                        fin_en = 1'b1;
                    end
                end
                MODE_STOP:
                begin
                    if (nxt.seq_step == 5'd0)
                    begin
                        nxt.sda_level = 1'b0; wait_en = 1'b1; wait_step = 5'd1;
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd2;
                    end
                    else if (nxt.seq_step == 5'd2)
                    begin
                        nxt.sda_level = 1'b1; wait_en = 1'b1; wait_step = 5'd3;
                    end
                    else
                    begin
                        fin_en = 1'b1;
                    end
                end
                MODE_WRITE:
                begin
                    if (nxt.seq_step == 5'd0)
                    begin
                        // MSB out, shift left
                        nxt.scl_level = 1'b0;
                        nxt.sda_level = nxt.shift_reg[7];
                        nxt.shift_reg = {nxt.shift_reg[6:0], 1'b0};
                        wait_en = 1'b1; wait_step = 5'd1;
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd2;
                    end
                    else if (nxt.seq_step == 5'd2)
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.bit_count = bc_inc;
                        wait_en   = 1'b1;
                        wait_step = (bc_inc < BITS_PER_BYTE) ? 5'd0 : 5'd4;
                    end
                    else if (nxt.seq_step == 5'd4)
                    begin
                        nxt.sda_level = 1'b1; wait_en = 1'b1; wait_step = 5'd5;
                    end
                    else if (nxt.seq_step == 5'd5)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd6;
                    end
                    else
                    begin
                        // ACK sample
                        nxt.scl_level = 1'b0; nxt.sda_level = 1'b1;
                        fin_en = 1'b1; fin_status = item.sda_in ? ST_NACK : ST_ACK;
                    end
                end
                MODE_READ:
                begin
                    if (nxt.seq_step == 5'd0)
                    begin
                        nxt.sda_level = 1'b1; nxt.scl_level = 1'b1;
                        wait_en = 1'b1; wait_step = 5'd1;
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        nxt.shift_reg = {cur.shift_reg[6:0], item.sda_in};
                        nxt.scl_level = 1'b0;
                        nxt.bit_count = bc_inc;
                        wait_en   = 1'b1;
                        wait_step = (bc_inc < BITS_PER_BYTE) ? 5'd0 : 5'd2;
                    end
                    else
                    begin
                        nxt.rx_hold = nxt.shift_reg;
                        fin_en = 1'b1;
                    end
                end
                MODE_ACK:
                begin
                    if (nxt.seq_step == 5'd0)
                    begin
                        nxt.sda_level = 1'b0; wait_en = 1'b1; wait_step = 5'd1;
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd2;
                    end
                    else if (nxt.seq_step == 5'd2)
                    begin
                        nxt.scl_level = 1'b0; wait_en = 1'b1; wait_step = 5'd3;
                    end
                    else
                    begin
                        nxt.sda_level = 1'b1; fin_en = 1'b1;
                    end
                end
                MODE_NACK:
                begin
                    if (nxt.seq_step == 5'd0)
                    begin
                        nxt.sda_level = 1'b1; wait_en = 1'b1; wait_step = 5'd1;
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        nxt.scl_level = 1'b1; wait_en = 1'b1; wait_step = 5'd2;
                    end
                    else if (nxt.seq_step == 5'd2)
                    begin
                        nxt.scl_level = 1'b0; wait_en = 1'b1; wait_step = 5'd3;
                    end
                    else
                    begin
                        fin_en = 1'b1;
                    end
                end
                default:
                begin
                    // bus recovery
                    if (nxt.seq_step == 5'd0)
                    begin
                        if (item.sda_in)
                        begin
                            fin_en = 1'b1;
                        end
                        else
                        begin
                            nxt.sda_level = 1'b1; nxt.scl_level = 1'b0;
                            wait_en = 1'b1; wait_step = 5'd1;
                        end
                    end
                    else if (nxt.seq_step == 5'd1)
                    begin
                        if (item.sda_in)
                        begin
                            // SDA freed: continue as first phase of a stop
                            nxt.active_mode = MODE_STOP;
                            nxt.sda_level   = 1'b0;
                            wait_en = 1'b1; wait_step = 5'd1;
                        end
                        else if (cur.bit_count >= BITS_PER_BYTE)
                        begin
                            fin_en = 1'b1; fin_status = ST_ERROR;
                        end
                        else
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.bit_count = bc_inc;
                            wait_en = 1'b1; wait_step = 5'd2;
                        end
                    end
                    else
                    begin
                        nxt.scl_level = 1'b0; wait_en = 1'b1; wait_step = 5'd1;
                    end
                end
            endcase
        end

        if (wait_en)
        begin
            nxt.seq_step   = wait_step;
            nxt.slot_count = slot_load;
        end
        if (fin_en)
        begin
            nxt.seq_step    = STEP_IDLE;
            nxt.slot_count  = '0;
            nxt.last_status = fin_status;
        end
        done = fin_en;
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
// Result path: an accepted input transaction waits in the input register; its step
// result goes to the output register, where the master side can take it, once that
// register is empty or being drained. Throughput: one tick per clock cycle while
// results are taken; the step from input to state/result registers is combinational.
// Reset (rst_n, async, active low): bus lines released, sequencer idle,
// status ready, slot length 1 tick, both pipeline registers empty.
`default_nettype none

module i2c_master_bit_engine
    import i2c_mbe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // slot length register
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] sda_in, rest zero
    input  wire logic [3:0]  s_axis_tuser,   // [0] cmd_valid, [3:1] mode

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [0] scl_out, [1] sda_out, [2] busy_res,
                                             // [3] done_res, [6:4] status, [14:7] rx_byte
);

    // configuration
    logic [15:0]    slot_ticks_reg;

    // input stage
    logic           in_valid_reg;
    i2c_mbe_item_t  in_item_reg;

    // sequencer state and result stage
    i2c_mbe_state_t state_reg;
    i2c_mbe_state_t state_next;
    logic           done_next;
    logic           out_valid_reg;
    logic [15:0]    out_data_reg;

    logic           advance;   // item in input stage is executed this cycle

    // The item moves on when the result register is empty or being drained;
    // the input stage refills in the same cycle, so one tick per clock while results drain.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ticks_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            slot_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.cmd_valid <= s_axis_tuser[0];
            in_item_reg.mode      <= s_axis_tuser[3:1];
            in_item_reg.tx_byte   <= s_axis_tdata[7:0];
            in_item_reg.sda_in    <= s_axis_tdata[8];
        end
    end

    i2c_mbe_step u_step
    (
        .cur        (state_reg),
        .item       (in_item_reg),
        .slot_ticks (slot_ticks_reg),
        .nxt        (state_next),
        .done       (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seq_step    <= STEP_IDLE;
            state_reg.active_mode <= MODE_START;
            state_reg.shift_reg   <= '0;
            state_reg.bit_count   <= '0;
            state_reg.slot_count  <= '0;
            state_reg.scl_level   <= 1'b1;
            state_reg.sda_level   <= 1'b1;
            state_reg.last_status <= ST_READY;
            state_reg.rx_hold     <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {1'b0,
                             state_next.rx_hold,
                             state_next.last_status,
                             done_next,
                             (state_next.seq_step != STEP_IDLE),
                             state_next.sda_level,
                             state_next.scl_level};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a finished command never reports itself as still running
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg[3] && out_data_reg[2]))
        else $error("done and busy both set in result");

    // a running command always has a slot count loaded
    a_busy_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.seq_step != STEP_IDLE) |-> (state_reg.slot_count != 16'd0))
        else $error("running command with empty slot count");

    // bit counter never runs past one byte
    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= BITS_PER_BYTE)
        else $error("bit counter beyond byte length");

    // an idle tick without command leaves the bus lines alone
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (state_reg.seq_step == STEP_IDLE) && !in_item_reg.cmd_valid) |=>
        ($stable(state_reg.scl_level) && $stable(state_reg.sda_level)))
        else $error("bus lines moved while idle");

endmodule

`default_nettype wire

// ===== sim/i2c_line_checker.sv =====
`timescale 1ns / 1ps

module i2c_line_checker
    import i2c_mbe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] sda_in
    input  wire logic [3:0]  s_axis_tuser,   // [0] cmd_valid, [3:1] mode
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // [0] scl, [1] sda, [2] busy, [3] done,
                                             // [6:4] status, [14:7] rx_byte
    output logic [31:0]      fail_count,
    output logic [31:0]      open_count
);

    // Same bit order as m_axis_tdata[14:0]
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [2:0] status;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } line_levels_t;

    line_levels_t levels_q[$];
    line_levels_t want;
    line_levels_t got;
    int           bad;

    // Predicted engine state
    logic [15:0] slot_len;
    logic [4:0]  step;
    logic [2:0]  run_mode;
    logic [7:0]  shifter;
    logic [3:0]  bit_cnt;
    logic [15:0] slot_left;
    logic        scl_q;
    logic        sda_q;
    logic [2:0]  last_st;
    logic [7:0]  rx_q;
    logic        done_q;

    function void hold_slot(input logic [4:0] nxt);
        step      = nxt;
        slot_left = (slot_len == 16'd0) ? 16'd1 : slot_len;
    endfunction

    function void close_cmd(input logic [2:0] st);
        step      = STEP_IDLE;
        slot_left = 16'd0;
        last_st   = st;
        done_q    = 1'b1;
    endfunction

    function void sequence_phase(input logic sda);
        case (run_mode)
            MODE_START:
                if (step == 0) begin sda_q = 1'b1; hold_slot(1); end
                else if (step == 1) begin scl_q = 1'b1; hold_slot(2); end
                else if (step == 2) begin
                    if (!sda) close_cmd(ST_BUSY);
                    else begin sda_q = 1'b0; hold_slot(3); end
                end
                else if (step == 3) begin scl_q = 1'b0; hold_slot(4); end
                else close_cmd(sda ? ST_ERROR : ST_READY);
            MODE_ALT_START:
                if (step == 0) begin sda_q = 1'b1; scl_q = 1'b0; hold_slot(1); end
                else if (step == 1) begin scl_q = 1'b1; hold_slot(2); end
                else if (step == 2) begin
                    if (!sda) close_cmd(ST_BUSY);
                    else begin sda_q = 1'b0; hold_slot(3); end
                end
                else if (step == 3) begin scl_q = 1'b0; hold_slot(4); end
                else if (step == 4) begin scl_q = 1'b1; hold_slot(5); end
                else if (step == 5) begin sda_q = 1'b1; hold_slot(6); end
                else if (step == 6) begin scl_q = 1'b0; hold_slot(7); end
                else close_cmd(ST_READY);
            MODE_STOP:
                if (step == 0) begin sda_q = 1'b0; hold_slot(1); end
                else if (step == 1) begin scl_q = 1'b1; hold_slot(2); end
                else if (step == 2) begin sda_q = 1'b1; hold_slot(3); end
                else close_cmd(ST_READY);
            MODE_WRITE:
                if (step == 0) begin
                    scl_q   = 1'b0;
                    sda_q   = shifter[7];
                    shifter = shifter << 1;
                    hold_slot(1);
                end
                else if (step == 1) begin scl_q = 1'b1; hold_slot(2); end
                else if (step == 2) begin
                    scl_q   = 1'b0;
                    bit_cnt = bit_cnt + 4'd1;
                    hold_slot((bit_cnt < BITS_PER_BYTE) ? 5'd0 : 5'd4);
                end
                else if (step == 4) begin sda_q = 1'b1; hold_slot(5); end
                else if (step == 5) begin scl_q = 1'b1; hold_slot(6); end
                else begin
                    scl_q = 1'b0;
                    sda_q = 1'b1;
                    close_cmd(sda ? ST_NACK : ST_ACK);
                end
            MODE_READ:
                if (step == 0) begin sda_q = 1'b1; scl_q = 1'b1; hold_slot(1); end
                else if (step == 1) begin
                    shifter = {shifter[6:0], sda};
                    scl_q   = 1'b0;
                    bit_cnt = bit_cnt + 4'd1;
                    hold_slot((bit_cnt < BITS_PER_BYTE) ? 5'd0 : 5'd2);
                end
                else begin rx_q = shifter; close_cmd(ST_READY); end
            MODE_ACK:
                if (step == 0) begin sda_q = 1'b0; hold_slot(1); end
                else if (step == 1) begin scl_q = 1'b1; hold_slot(2); end
                else if (step == 2) begin scl_q = 1'b0; hold_slot(3); end
                else begin sda_q = 1'b1; close_cmd(ST_READY); end
            MODE_NACK:
                if (step == 0) begin sda_q = 1'b1; hold_slot(1); end
                else if (step == 1) begin scl_q = 1'b1; hold_slot(2); end
                else if (step == 2) begin scl_q = 1'b0; hold_slot(3); end
                else close_cmd(ST_READY);
            default:   // bus recovery
                if (step == 0) begin
                    if (sda) close_cmd(ST_READY);
                    else begin sda_q = 1'b1; scl_q = 1'b0; hold_slot(1); end
                end
                else if (step == 1) begin
                    if (sda) begin
                        // line came free: fall into the first stop phase
                        run_mode = MODE_STOP;
                        sda_q    = 1'b0;
                        hold_slot(1);
                    end
                    else if (bit_cnt >= BITS_PER_BYTE) close_cmd(ST_ERROR);
                    else begin
                        scl_q   = 1'b1;
                        bit_cnt = bit_cnt + 4'd1;
                        hold_slot(2);
                    end
                end
                else begin scl_q = 1'b0; hold_slot(1); end
        endcase
    endfunction

    function line_levels_t bus_tick(input logic cv, input logic [2:0] md,
                                    input logic [7:0] tx, input logic sda);
        line_levels_t r;
        done_q = 1'b0;
        if (step == STEP_IDLE) begin
            if (cv) begin
                run_mode = md;
                shifter  = (md == MODE_WRITE) ? tx : 8'h00;
                bit_cnt  = 4'd0;
                step     = 5'd0;
                sequence_phase(sda);
            end
        end
        else if (slot_left > 16'd1)
            slot_left = slot_left - 16'd1;
        else
            sequence_phase(sda);
        r.scl     = scl_q;
        r.sda     = sda_q;
        r.busy    = (step != STEP_IDLE);
        r.done    = done_q;
        r.status  = last_st;
        r.rx_byte = rx_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slot_len   = 16'd1;
            step       = STEP_IDLE;
            run_mode   = MODE_START;
            shifter    = 8'h00;
            bit_cnt    = 4'd0;
            slot_left  = 16'd0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            last_st    = ST_READY;
            rx_q       = 8'h00;
            done_q     = 1'b0;
            bad        = 0;
            levels_q.delete();
            fail_count <= '0;
            open_count <= '0;
        end
        else begin
            if (cfg_wr_en)
                slot_len = cfg_wr_data;

            // check before predicting: a result never shares an edge with its own input
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[14:0];
                if (levels_q.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected result %h with nothing outstanding", got);
                end
                else begin
                    want = levels_q.pop_front();
                    if (got.scl !== want.scl || got.sda !== want.sda ||
                        got.busy !== want.busy || got.done !== want.done ||
                        got.status !== want.status || got.rx_byte !== want.rx_byte) begin
                        bad++;
                        if (bad <= 10) begin
                            $display("mismatch at %0t: exp scl %b sda %b busy %b done %b status %0d rx %h",
                                     $realtime, want.scl, want.sda, want.busy, want.done,
                                     want.status, want.rx_byte);
                            $display("    got scl %b sda %b busy %b done %b status %0d rx %h",
                                     got.scl, got.sda, got.busy, got.done,
                                     got.status, got.rx_byte);
                        end
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                levels_q.push_back(bus_tick(s_axis_tuser[0], s_axis_tuser[3:1],
                                            s_axis_tdata[7:0], s_axis_tdata[8]));

            fail_count <= bad;
            open_count <= levels_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import i2c_mbe_pkg::*;

    // Ceiling on consecutive cycles with no transaction on either side.
    // Longest legal quiet stretch is the long receiver hold of HOLD_CYCLES.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    // Ceiling on idle ticks spent waiting for one command to finish
    localparam int DRAIN_LIMIT  = 2000;

    // How the stimulus drives the sampled SDA line
    localparam logic [1:0] SDA_RANDOM = 2'd0;   // new coin flip every tick
    localparam logic [1:0] SDA_LOW    = 2'd1;   // held low by a slave
    localparam logic [1:0] SDA_HIGH   = 2'd2;   // released
    localparam logic [1:0] SDA_DRIFT  = 2'd3;   // long runs, rare toggles

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;   // [7:0] tx_byte, [8] sda_in, rest zero
    logic [3:0]  s_axis_tuser  = 4'd0;    // [0] cmd_valid, [3:1] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [0] scl, [1] sda, [2] busy, [3] done,
                                          // [6:4] status, [14:7] rx_byte

    logic [31:0] fail_count;
    logic [31:0] open_count;

    // Stimulus bookkeeping
    int          n_in      = 0;      // ticks accepted by the engine
    int          n_out     = 0;      // results taken from the engine
    logic        last_busy = 1'b0;   // busy flag of the newest result
    logic        idle_on   = 1'b1;   // random bubbles on both sides
    logic        hold_req  = 1'b0;   // one long receiver hold-off
    logic [1:0]  sda_style = SDA_RANDOM;
    logic        sda_now   = 1'b1;
    int          script_pos = 0;

    // Plausible bus transaction order; the random part mostly walks this
    logic [2:0]  script [8] = '{MODE_START, MODE_WRITE, MODE_WRITE, MODE_READ,
                                MODE_ACK, MODE_READ, MODE_NACK, MODE_STOP};

    i2c_master_bit_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    i2c_line_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .open_count    (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side bookkeeping, used only to know when the engine has gone idle
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            n_out     <= n_out + 1;
            last_busy <= m_axis_tdata[2];
        end
    end

    // Receiver: random stall bursts, plus one long hold when asked, so the
    // pipeline fills and the input side has to back off.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: any transaction on either side clears the quiet counter
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("i2c_master_bit_engine regression: fail");
        $finish;
    end

    // Next sampled SDA level under the current line style
    function automatic logic pick_sda();
        case (sda_style)
            SDA_LOW:   sda_now = 1'b0;
            SDA_HIGH:  sda_now = 1'b1;
            SDA_DRIFT: if ($urandom_range(0, 15) == 0) sda_now = ~sda_now;
            default:   sda_now = 1'($urandom_range(0, 1));
        endcase
        return sda_now;
    endfunction

    // One tick into the engine. An optional bubble comes first, so tvalid
    // is never lowered and raised within one time step.
    task automatic send_tick(input logic cv, input logic [2:0] md,
                             input logic [7:0] tx, input logic sda);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, sda, tx};
        s_axis_tuser  <= {md, cv};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_in++;
    endtask

    // Keep ticking with no command until the newest result shows the
    // engine idle and every result is back; bounded so a stuck engine
    // cannot keep the run alive.
    task automatic drain_engine(input logic [1:0] style);
        logic       settled;
        logic [2:0] md;
        logic [7:0] tx;
        int         guard;
        settled   = 1'b0;
        guard     = 0;
        sda_style = style;
        while (!settled && guard < DRAIN_LIMIT)
        begin
            while (last_busy && guard < DRAIN_LIMIT)
            begin
                md = 3'($urandom_range(0, 7));
                tx = 8'($urandom);
                send_tick(1'b0, md, tx, pick_sda());
                guard++;
            end
            s_axis_tvalid <= 1'b0;
            while (n_out != n_in)
                @(posedge clk);
            settled = !last_busy;
        end
    endtask

    // One command, then run it to completion under a given line style
    task automatic issue(input logic [2:0] md, input logic [7:0] tx, input logic [1:0] style);
        sda_style = style;
        send_tick(1'b1, md, tx, pick_sda());
        drain_engine(style);
    endtask

    // Slot length write; only called with the engine idle and drained
    task automatic write_slot(input logic [15:0] ticks);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random traffic: mostly commands in bus order, some random modes as noise,
    // SDA style reshuffled every 40 ticks so ACK/NACK, bus busy/error and
    // full recovery runs all show up.
    task automatic run_traffic(input int n_ticks);
        logic       cv;
        logic [2:0] md;
        logic [7:0] tx;
        for (int i = 0; i < n_ticks; i++)
        begin
            if (i % 40 == 0)
                sda_style = 2'($urandom_range(0, 3));
            cv = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                md = 3'($urandom_range(0, 7));
            else
                md = script[script_pos];
            if (cv)
                script_pos = (script_pos + 1) % 8;
            tx = 8'($urandom);
            send_tick(cv, md, tx, pick_sda());
        end
        drain_engine(SDA_RANDOM);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, slot length at its reset value of one tick ----

        // clean start: line high up to the SDA check, low when SCL falls
        send_tick(1'b1, MODE_START, 8'h00, 1'b1);
        repeat (3) send_tick(1'b0, MODE_START, 8'hFF, 1'b1);
        drain_engine(SDA_LOW);
        issue(MODE_START, 8'h00, SDA_HIGH);      // SDA never follows: bus error
        issue(MODE_START, 8'hFF, SDA_LOW);       // SDA held low: bus busy
        issue(MODE_ALT_START, 8'h00, SDA_HIGH);
        issue(MODE_ALT_START, 8'hFF, SDA_LOW);
        issue(MODE_STOP, 8'h5A, SDA_RANDOM);
        issue(MODE_WRITE, 8'hFF, SDA_LOW);       // acked
        issue(MODE_WRITE, 8'h00, SDA_HIGH);      // not acked
        issue(MODE_WRITE, 8'hA5, SDA_RANDOM);
        issue(MODE_READ, 8'h00, SDA_HIGH);       // reads all ones
        issue(MODE_READ, 8'hFF, SDA_LOW);        // reads all zeros
        issue(MODE_READ, 8'h3C, SDA_RANDOM);
        issue(MODE_ACK, 8'h81, SDA_RANDOM);
        issue(MODE_NACK, 8'h7E, SDA_RANDOM);
        issue(MODE_RECOVER, 8'h00, SDA_HIGH);    // line already free
        issue(MODE_RECOVER, 8'hFF, SDA_LOW);     // stuck through all pulses

        // recovery where the slave lets go after a few pulses
        send_tick(1'b1, MODE_RECOVER, 8'h11, 1'b0);
        repeat (6) send_tick(1'b0, MODE_RECOVER, 8'hEE, 1'b0);
        drain_engine(SDA_HIGH);

        // commands offered while busy and on the done tick must be dropped;
        // the fifth one lands after done and starts a read
        send_tick(1'b1, MODE_STOP, 8'h00, 1'b1);
        repeat (4) send_tick(1'b1, MODE_READ, 8'hC3, 1'b1);
        drain_engine(SDA_DRIFT);

        // ---- random phases over several slot lengths ----

        write_slot(16'd0);           // zero acts as one tick
        run_traffic(200);

        write_slot(16'd2);
        hold_req = 1'b1;             // long receiver hold while ticks keep coming
        run_traffic(200);

        write_slot(16'd3);
        run_traffic(200);

        // long slot: a single stop, no bubbles
        idle_on = 1'b0;
        write_slot(16'd16);
        issue(MODE_STOP, 8'h00, SDA_RANDOM);
        idle_on = 1'b1;

        write_slot(16'($urandom_range(4, 9)));
        run_traffic(200);

        // last part: shortest slot, full rate on both sides
        idle_on = 1'b0;
        write_slot(16'd1);
        run_traffic(300);

        // let the pipeline settle before the verdict
        repeat (10) @(posedge clk);

        if (fail_count == 0 && open_count == 0)
            $display("i2c_master_bit_engine regression: pass");
        else
            $display("i2c_master_bit_engine regression: fail");
        $finish;
    end

endmodule

// ===== i2c_master_bit_engine.f =====
rtl/i2c_mbe_pkg.sv
rtl/i2c_mbe_step.sv
rtl/i2c_master_bit_engine.sv
sim/i2c_line_checker.sv
sim/testbench.sv
